[design/kss_pkg.sv]
// ----------------------------------------------------------------------------
// kss_pkg: shared definitions of the shared-store stack block
// Sizes, the null link code, result status codes, controller states and the
// power-up contents of the link store.
// ----------------------------------------------------------------------------
package kss_pkg;

  // Number of stacks and number of entries in the shared store.
  localparam int NUM_STACKS = 4;
  localparam int CAPACITY   = 16;

  // Entry address width and link width (one extra code stands for null).
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int LINK_W = $clog2(CAPACITY + 1);

  // Field widths of the transfers.
  localparam int SID_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // Null link: one past the last entry.
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

  // Data returned by a pop from an empty stack.
  localparam logic signed [DATA_W-1:0] EMPTY_DATA = 32'sh7FFF_FFFF;

  // Opcodes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } state_e;

  // Link held by an entry that was never written: the next entry, or null.
  function automatic logic [LINK_W-1:0] link_reset(input logic [ADDR_W-1:0] addr);
    logic [LINK_W-1:0] nxt;
    nxt = LINK_W'(addr) + LINK_W'(1);
    return (nxt >= NIL_LINK) ? NIL_LINK : nxt;
  endfunction

endpackage

[design/kss_if.sv]
// ----------------------------------------------------------------------------
// kss_if: valid/ready channel interfaces of the shared-store stack block
// One interface for the operation requests and one for the results.
// ----------------------------------------------------------------------------
interface kss_in_if
  import kss_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [SID_W-1:0]         stack_id;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, opcode, stack_id, value, input ready);
  modport sink   (input valid, opcode, stack_id, value, output ready);
endinterface

interface kss_out_if
  import kss_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] data;

  modport source (output valid, status, data, input ready);
  modport sink   (input valid, status, data, output ready);
endinterface

[design/k_stacks_shared_store_top.sv]
// ----------------------------------------------------------------------------
// k_stacks_shared_store_top: several stacks in one shared entry store
// Push and pop on four stacks whose entries come from one free list.
// ----------------------------------------------------------------------------
// In each operation, the entry at the head of the free list (push) or at the
// top of the chosen stack (pop) is first read from the link and value
// memories, which have a registered read port; then the links and heads are
// rewritten and the result is loaded into the output register. The link
// memory starts out chained in order through per-entry valid bits, so the
// block is ready right after reset with no clearing pass. A new request is
// taken once the previous one has committed; a result that waits in the
// output register holds the commit cycle. A push into a full store answers
// full with data zero, a pop from an empty stack answers empty with data
// 2147483647, and neither changes any state.
module k_stacks_shared_store_top
  import kss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  kss_in_if.sink      in_i,
  kss_out_if.source   out_o
);

  // Controller state and the captured request.
  state_e                   state_q, state_d;
  logic                     op_q;
  logic [SID_W-1:0]         sid_q;
  logic signed [DATA_W-1:0] val_q;
  logic                     err_q;
  logic [ADDR_W-1:0]        addr_q;

  // Stack tops and the free list head.
  logic [LINK_W-1:0] heads_q [NUM_STACKS];
  logic [LINK_W-1:0] free_head_q;

  // Link and value memories with registered read data.
  logic [LINK_W-1:0]        link_mem [CAPACITY];
  logic signed [DATA_W-1:0] value_mem [CAPACITY];
  logic [LINK_W-1:0]        link_rd_q;
  logic signed [DATA_W-1:0] value_rd_q;
  logic [CAPACITY-1:0]      link_vld_q;
  logic                     link_init_q;

  // Output register.
  logic                     out_valid_q;
  logic [STATUS_W-1:0]      out_status_q;
  logic signed [DATA_W-1:0] out_data_q;

  logic              accept;
  logic              commit;
  logic              sid_bad;
  logic [LINK_W-1:0] slot_sel;
  logic              req_err;
  logic [LINK_W-1:0] link_cur;
  logic              link_we;
  logic [LINK_W-1:0] link_wdata;
  logic              value_we;

  // Request side: one operation at a time.
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // The result can be loaded once the output register is free or drains now.
  assign commit = (state_q == S_COMMIT) && (!out_valid_q || out_o.ready);

  // Entry the request works on, and whether it fails at once.
  always_comb begin
    sid_bad  = (32'(in_i.stack_id) >= NUM_STACKS);
    slot_sel = NIL_LINK;
    if (!sid_bad) begin
      slot_sel = (in_i.opcode == OP_POP) ? heads_q[in_i.stack_id] : free_head_q;
    end
    req_err = sid_bad || (slot_sel >= NIL_LINK);
  end

  // Link read back from memory, or its power-up value if never written.
  assign link_cur = link_init_q ? link_reset(addr_q) : link_rd_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the request at its transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.opcode;
      sid_q  <= in_i.stack_id;
      val_q  <= in_i.value;
      err_q  <= req_err;
      addr_q <= slot_sel[ADDR_W-1:0];
    end
  end

  // Link memory write: a pushed entry links to the old top, a popped entry
  // links to the old free head.
  assign link_we    = commit && !err_q;
  assign link_wdata = (op_q == OP_POP) ? free_head_q : heads_q[sid_q];
  assign value_we   = link_we && (op_q == OP_PUSH);

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[addr_q] <= link_wdata;
    end
    if (accept) begin
      link_rd_q <= link_mem[slot_sel[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (value_we) begin
      value_mem[addr_q] <= val_q;
    end
    if (accept) begin
      value_rd_q <= value_mem[slot_sel[ADDR_W-1:0]];
    end
  end

  // Written marks of the link memory; unmarked entries read their power-up link.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q  <= '0;
      link_init_q <= 1'b0;
    end else begin
      if (link_we) begin
        link_vld_q[addr_q] <= 1'b1;
      end
      if (accept) begin
        link_init_q <= !link_vld_q[slot_sel[ADDR_W-1:0]];
      end
    end
  end

  // Stack heads and the free list head are updated at commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        heads_q[i] <= NIL_LINK;
      end
      free_head_q <= '0;
    end else if (link_we) begin
      if (op_q == OP_PUSH) begin
        free_head_q    <= link_cur;
        heads_q[sid_q] <= LINK_W'(addr_q);
      end else begin
        heads_q[sid_q] <= link_cur;
        free_head_q    <= LINK_W'(addr_q);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      if (op_q == OP_PUSH) begin
        out_status_q <= err_q ? ST_FULL : ST_OK;
        out_data_q   <= '0;
      end else begin
        out_status_q <= err_q ? ST_EMPTY : ST_OK;
        out_data_q   <= err_q ? EMPTY_DATA : value_rd_q;
      end
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.data   = out_data_q;

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the shared-store stack block
// Drives push and pop requests over the request channel and checks every
// result against a bench-side model of the stacks and the free list. A short
// table covers empty pops, extreme words and a full store. Random phases that
// lean toward pushes or pops then fill and drain the store many times over.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import kss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is declared hung.
  localparam int HANG_LIMIT   = 5000;
  localparam int RAND_ITEMS   = 700;
  localparam int PHASE_ITEMS  = 70;
  localparam int QUIET_FIRST  = 250;
  localparam int QUIET_LAST   = 399;
  localparam int DRAIN_AT     = 500;
  localparam int TAIL_CYCLES  = 10;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
  } stack_result_t;

  typedef struct {
    logic                     op;
    logic [SID_W-1:0]         sid;
    logic signed [DATA_W-1:0] word;
    bit                       typed;
    status_e                  t_status;
    logic signed [DATA_W-1:0] t_data;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  kss_in_if  op_ch ();
  kss_out_if res_ch ();

  k_stacks_shared_store_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_ch),
    .out_o  (res_ch)
  );

  // Bench copy of the stack heads, links, entry words and free list head.
  logic [LINK_W-1:0]        top_of [NUM_STACKS];
  logic [LINK_W-1:0]        next_of [CAPACITY];
  logic signed [DATA_W-1:0] entry_word [CAPACITY];
  logic [LINK_W-1:0]        free_top;

  stack_result_t expected_results [$];
  plan_row_t     directed_rows [$];
  bit            quiet;
  int            fail_count;
  int            idle_cycles;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Model state after reset: every stack empty, free list chained in order.
  function automatic void clear_stacks();
    for (int i = 0; i < NUM_STACKS; i++) top_of[i] = NIL_LINK;
    for (int i = 0; i < CAPACITY; i++) begin
      next_of[i]    = (i + 1 < CAPACITY) ? LINK_W'(i + 1) : NIL_LINK;
      entry_word[i] = '0;
    end
    free_top = '0;
  endfunction

  // Applies one push or pop to the model and gives the result it causes.
  function automatic void apply_stack_op(input logic op, input logic [SID_W-1:0] sid,
                                         input logic signed [DATA_W-1:0] word,
                                         output stack_result_t res);
    logic [ADDR_W-1:0] slot;
    if (op == OP_PUSH) begin
      if (int'(sid) >= NUM_STACKS || free_top >= NIL_LINK) begin
        res = '{status: ST_FULL, data: '0};
      end else begin
        slot             = free_top[ADDR_W-1:0];
        free_top         = next_of[slot];
        next_of[slot]    = top_of[sid];
        top_of[sid]      = LINK_W'(slot);
        entry_word[slot] = word;
        res = '{status: ST_OK, data: '0};
      end
    end else begin
      if (int'(sid) >= NUM_STACKS || top_of[sid] >= NIL_LINK) begin
        res = '{status: ST_EMPTY, data: EMPTY_DATA};
      end else begin
        slot          = top_of[sid][ADDR_W-1:0];
        top_of[sid]   = next_of[slot];
        next_of[slot] = free_top;
        free_top      = LINK_W'(slot);
        res = '{status: ST_OK, data: entry_word[slot]};
      end
    end
  endfunction

  function automatic void add_row(input logic op, input logic [SID_W-1:0] sid,
                                  input logic signed [DATA_W-1:0] word, input bit typed,
                                  input status_e t_status,
                                  input logic signed [DATA_W-1:0] t_data);
    plan_row_t row;
    row = '{op: op, sid: sid, word: word, typed: typed, t_status: t_status,
            t_data: t_data};
    directed_rows.push_back(row);
  endfunction

  // Offers one request, waits for its transfer and records what must come back.
  task automatic issue_op(input logic op, input logic [SID_W-1:0] sid,
                          input logic signed [DATA_W-1:0] word, input bit typed,
                          input status_e t_status, input logic signed [DATA_W-1:0] t_data);
    stack_result_t res;
    while (!quiet && $urandom_range(99) < 20) begin
      op_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    op_ch.valid    <= 1'b1;
    op_ch.opcode   <= op;
    op_ch.stack_id <= sid;
    op_ch.value    <= word;
    @(posedge clk_i);
    while (!op_ch.ready) @(posedge clk_i);
    apply_stack_op(op, sid, word, res);
    if (typed) res = '{status: t_status, data: t_data};
    expected_results.push_back(res);
  endtask

  // Holds the sender back until every outstanding result has been seen.
  task automatic wait_for_drain();
    op_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random back-pressure except during the quiet stretch.
  always @(posedge clk_i) begin
    res_ch.ready <= quiet || ($urandom_range(99) >= 20);
  end

  // Result checker: compares each transfer with the oldest expectation.
  always @(posedge clk_i) begin
    stack_result_t exp_res;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d, data %0d", res_ch.status, res_ch.data);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (res_ch.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, res_ch.status);
          fail_count++;
        end
        if (res_ch.data !== exp_res.data) begin
          $error("data: expected %0d, got %0d", exp_res.data, res_ch.data);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Stimulus: directed table, then random phases.
  initial begin
    logic signed [DATA_W-1:0] extremes [4];
    int                       push_pct [5];
    int                       pct;
    int                       focus;
    bit                       focused;
    logic                     op;
    logic [SID_W-1:0]         sid;
    logic signed [DATA_W-1:0] word;
    plan_row_t                row;

    extremes = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, -32'sd1};
    push_pct = '{85, 65, 50, 35, 15};

    op_ch.valid    = 1'b0;
    op_ch.opcode   = OP_PUSH;
    op_ch.stack_id = '0;
    op_ch.value    = '0;
    res_ch.ready   = 1'b0;
    quiet          = 1'b0;
    fail_count     = 0;
    idle_cycles    = 0;
    rst_ni         = 1'b0;
    clear_stacks();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every stack is empty after reset.
    for (int s = 0; s < NUM_STACKS; s++)
      add_row(OP_POP, SID_W'(s), '0, 1'b1, ST_EMPTY, EMPTY_DATA);
    // Extreme words go in and come back out in last-in order.
    add_row(OP_PUSH, 2'd0, 32'sh7FFF_FFFF, 1'b1, ST_OK, '0);
    add_row(OP_PUSH, 2'd1, 32'sh8000_0000, 1'b1, ST_OK, '0);
    add_row(OP_POP,  2'd1, 32'sh1234_5678, 1'b0, ST_OK, '0);
    add_row(OP_POP,  2'd0, '0,             1'b0, ST_OK, '0);
    // Fill the whole store across all stacks.
    for (int i = 0; i < CAPACITY; i++) begin
      case (i % 4)
        0: word = '0;
        1: word = -32'sd1;
        2: word = 32'sh5555_5555;
        default: word = 32'shAAAA_AAAA;
      endcase
      add_row(OP_PUSH, SID_W'(i % NUM_STACKS), word ^ DATA_W'(i), 1'b1, ST_OK, '0);
    end
    // A push into the full store is refused; a pop frees an entry again.
    add_row(OP_PUSH, 2'd2, 32'sh0BAD_CAFE, 1'b1, ST_FULL, '0);
    add_row(OP_POP,  2'd3, '0,             1'b0, ST_OK,   '0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      issue_op(row.op, row.sid, row.word, row.typed, row.t_status, row.t_data);
    end
    wait_for_drain();

    // Random phases alternate between filling and draining the store.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        pct     = push_pct[3'((n / PHASE_ITEMS) % 5)];
        focus   = $urandom_range(NUM_STACKS - 1);
        focused = 1'($urandom_range(1));
      end
      if (n == DRAIN_AT) wait_for_drain();
      quiet = (n >= QUIET_FIRST && n <= QUIET_LAST);
      op    = ($urandom_range(99) < pct) ? OP_PUSH : OP_POP;
      if (focused && $urandom_range(3) != 0) sid = SID_W'(focus);
      else sid = SID_W'($urandom_range(3));
      if ($urandom_range(9) == 0) word = extremes[2'($urandom_range(3))];
      else word = $signed($urandom);
      issue_op(op, sid, word, 1'b0, ST_OK, '0);
    end
    quiet = 1'b0;

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
